FILE: design/accumulator_machine_execute_top_macros.svh
// Assertion macros for the accumulator machine execute block
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AME_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define AME_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define AME_ASSERT_IMP(label, clk, rst, cond, prop)
`define AME_ASSERT_NXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: design/ame_pkg.sv
// Types, opcodes and constants shared by the accumulator machine execute block
package ame_pkg;

   localparam int WORD_W            = 32;
   localparam int ADDR_W            = 7;
   localparam int MODE_W            = 7;
   localparam int DEFAULT_MEM_WORDS = 128;
   localparam int CNT_W             = $clog2(WORD_W);

   localparam logic [MODE_W-1:0] OP_READ    = MODE_W'(10);
   localparam logic [MODE_W-1:0] OP_WRITE   = MODE_W'(11);
   localparam logic [MODE_W-1:0] OP_LOAD    = MODE_W'(20);
   localparam logic [MODE_W-1:0] OP_STORE   = MODE_W'(21);
   localparam logic [MODE_W-1:0] OP_ADD     = MODE_W'(30);
   localparam logic [MODE_W-1:0] OP_SUB     = MODE_W'(31);
   localparam logic [MODE_W-1:0] OP_DIV     = MODE_W'(32);
   localparam logic [MODE_W-1:0] OP_MUL     = MODE_W'(33);
   localparam logic [MODE_W-1:0] OP_JUMP    = MODE_W'(40);
   localparam logic [MODE_W-1:0] OP_JNOTPOS = MODE_W'(41);
   localparam logic [MODE_W-1:0] OP_JZERO   = MODE_W'(42);
   localparam logic [MODE_W-1:0] OP_HALT    = MODE_W'(43);
   localparam logic [MODE_W-1:0] OP_JEVEN   = MODE_W'(58);

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] read_value;
   } ame_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] accumulator_value;
      logic signed [WORD_W-1:0] output_value;
      logic                     output_valid;
      logic                     branch_taken;
      logic [ADDR_W-1:0]        branch_target;
      logic                     command_error;
      logic                     divide_by_zero;
      logic                     halted;
   } ame_rsp_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } ame_div_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WORD_W-1:0] quotient;
   } ame_div_stat_type;

endpackage

FILE: design/ame_if.sv
// Valid/ready request and response channels
interface ame_req_if;
   logic                 valid;
   logic                 ready;
   ame_pkg::ame_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ame_rsp_if;
   logic                 valid;
   logic                 ready;
   ame_pkg::ame_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ame_divider.sv
// Signed truncating divider, restoring, one quotient bit per cycle
module ame_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  ame_pkg::ame_div_ctrl_type ctrl,
   output ame_pkg::ame_div_stat_type stat
);
   import ame_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   trial;
   logic              fits;

   always_comb begin
      shifted  = {rem_ff, quo_ff[WORD_W-1]};
      trial    = shifted - {1'b0, den_ff};
      fits     = !trial[WORD_W];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         // magnitudes; the most negative word stays as 2^31 unsigned
         quo_in   = ctrl.dividend[WORD_W-1] ? (WORD_W'(0) - ctrl.dividend) : ctrl.dividend;
         den_in   = ctrl.divisor[WORD_W-1] ? (WORD_W'(0) - ctrl.divisor) : ctrl.divisor;
         neg_in   = ctrl.dividend[WORD_W-1] ^ ctrl.divisor[WORD_W-1];
      end else if (busy_ff) begin
         rem_in   = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
         quo_in   = {quo_ff[WORD_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(WORD_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = neg_ff ? (WORD_W'(0) - quo_ff) : quo_ff;

endmodule

FILE: design/accumulator_machine_execute_top.sv
// Execute unit of a small accumulator machine: word memory, accumulator, sticky flags
// A request runs in EXEC, a nonzero divide then in DIV (bit-serial divider), and OUT
// moves the result to the response register when free; requests are taken only in IDLE.
// The memory has one read and one write port; each request reads one word, and READ and
// STORE write one. Reset clears accumulator and flags, then zeroes all MEM_WORDS words
// with req ready held low; the response register can hold one finished result.
`include "accumulator_machine_execute_top_macros.svh"

module accumulator_machine_execute_top #(
   parameter int MEM_WORDS = ame_pkg::DEFAULT_MEM_WORDS
) (
   input logic       clock,
   input logic       reset,
   ame_req_if.sink   req_if,
   ame_rsp_if.source rsp_if
);
   import ame_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              cmd_err_ff, cmd_err_in;
   logic              div0_ff, div0_in;
   logic              halted_ff, halted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ame_rsp_type       rsp_data_ff, rsp_data_in;
   ame_rsp_type       res_ff, res_in;

   logic [MODE_W-1:0] mode_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [AW-1:0]     idx_ff;
   logic [WORD_W-1:0] rv_ff;

   logic [WORD_W-1:0] word_mem [MEM_WORDS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   logic              accept;
   logic [ADDR_W-1:0] addr_red;
   logic [AW-1:0]     req_idx;

   logic              taken;
   logic [ADDR_W-1:0] target;
   logic [WORD_W-1:0] outv;
   logic              outvalid;

   ame_div_ctrl_type  div_ctrl;
   ame_div_stat_type  div_stat;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // address modulo MEM_WORDS by conditional subtraction of shifted multiples
   always_comb begin
      addr_red = req_if.payload.address;
      for (int k = ADDR_W - 1; k >= 0; k--) begin
         if (32'(addr_red) >= (32'(MEM_WORDS) << k)) begin
            addr_red = addr_red - ADDR_W'(32'(MEM_WORDS) << k);
         end
      end
      req_idx = AW'(addr_red);
   end

   ame_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      acc_in            = acc_ff;
      cmd_err_in        = cmd_err_ff;
      div0_in           = div0_ff;
      halted_in         = halted_ff;
      res_in            = res_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in       = rsp_data_ff;
      mem_we            = 1'b0;
      mem_waddr         = idx_ff;
      mem_wdata         = acc_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = acc_ff;
      div_ctrl.divisor  = mem_rdata_ff;
      taken             = 1'b0;
      target            = '0;
      outv              = '0;
      outvalid          = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            unique case (mode_ff)
               OP_READ: begin
                  mem_we    = 1'b1;
                  mem_wdata = rv_ff;
               end
               OP_WRITE: begin
                  outv     = mem_rdata_ff;
                  outvalid = 1'b1;
               end
               OP_LOAD:  acc_in = mem_rdata_ff;
               OP_STORE: mem_we = 1'b1;
               OP_ADD:   acc_in = acc_ff + mem_rdata_ff;
               OP_SUB:   acc_in = acc_ff - mem_rdata_ff;
               OP_MUL:   acc_in = acc_ff * mem_rdata_ff;
               OP_DIV: begin
                  if (mem_rdata_ff == '0) begin
                     div0_in = 1'b1;
                  end else begin
                     div_ctrl.start = 1'b1;
                     state_in       = ST_DIV;
                  end
               end
               OP_JUMP: begin
                  taken  = 1'b1;
                  target = addr_ff;
               end
               OP_JNOTPOS: begin
                  if (acc_ff[WORD_W-1] || acc_ff == '0) begin
                     taken  = 1'b1;
                     target = addr_ff;
                  end
               end
               OP_JZERO: begin
                  if (acc_ff == '0) begin
                     taken  = 1'b1;
                     target = addr_ff;
                  end
               end
               OP_HALT: begin
                  halted_in = 1'b1;
                  taken     = 1'b1;
               end
               OP_JEVEN: begin
                  if (!acc_ff[0]) begin
                     taken  = 1'b1;
                     target = addr_ff;
                  end
               end
               default: cmd_err_in = 1'b1;
            endcase
         end
         ST_DIV: begin
            if (div_stat.done) begin
               acc_in   = div_stat.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // pending result tracks the architectural state as it settles
      if (state_ff == ST_EXEC || state_ff == ST_DIV) begin
         res_in.accumulator_value = acc_in;
         res_in.output_value      = outv;
         res_in.output_valid      = outvalid;
         res_in.branch_taken      = taken;
         res_in.branch_target     = target;
         res_in.command_error     = cmd_err_in;
         res_in.divide_by_zero    = div0_in;
         res_in.halted            = halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         cmd_err_ff   <= 1'b0;
         div0_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         acc_ff       <= acc_in;
         cmd_err_ff   <= cmd_err_in;
         div0_ff      <= div0_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      if (accept) begin
         mode_ff <= req_if.payload.mode;
         addr_ff <= req_if.payload.address;
         idx_ff  <= req_idx;
         rv_ff   <= req_if.payload.read_value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mem_rdata_ff <= word_mem[req_idx];
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   `AME_ASSERT_NXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
   `AME_ASSERT_NXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `AME_ASSERT_IMP(a_div_nonzero, clock, reset, div_ctrl.start, div_ctrl.divisor != '0)
   `AME_ASSERT_IMP(a_div_busy, clock, reset, state_ff == ST_DIV && !div_stat.done, div_stat.busy)

endmodule
